// ----- hw/rtl/pcf_pkg.sv -----
package pcf_pkg;

  localparam int HEADER_BYTES    = 14;
  localparam int BYTES_EACH_MS   = 32;
  localparam int MAX_CHUNK_BYTES = 2048;
  localparam int DURATION_MIN    = 1;
  localparam int DURATION_MAX    = 64;
  localparam int DURATION_RESET  = 32;

  localparam int DUR_W  = 7;
  localparam int FILL_W = 11;
  localparam int OFF_W  = 12;
  localparam int TS_W   = 64;
  localparam int HIDX_W = 4;

  localparam logic [7:0] SIG0 = 8'hC0;
  localparam logic [7:0] SIG1 = 8'hFF;
  localparam logic [7:0] SIG2 = 8'hEE;
  localparam logic [7:0] SIG3 = 8'hEE;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_DURATION = 2'd0;
  localparam logic [1:0] CFG_START_TS = 2'd1;
  localparam logic [1:0] CFG_END_ZERO = 2'd2;

  // input function codes
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [OFF_W-1:0] store_offset;
    logic [7:0]       store_value;
    logic             packet_commit;
    logic [OFF_W-1:0] packet_length;
    logic             run_last;
  } out_word_t;

endpackage

// ----- hw/rtl/pcm_chunk_packet_framer_top.sv -----
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data  (pcf_pkg::in_word_t)
// out       output     out_valid / out_ready  out_data (pcf_pkg::out_word_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index (2 b), cfg_value (64 b)
//
// A data byte that does not close a chunk makes one word; one word leaves per cycle while out is not stalled.
// Closing a chunk, or an end marker with the zero-size option, adds a 14-word header
// burst from the header byte counter; in_ready is low while that header is sent.
// Synchronous reset: duration 32, timestamp 0, zero-size option off, chunk empty.
// The output register frees up in the cycle it is taken, so a stall on out
// holds in_ready low only while a word is waiting.
module pcm_chunk_packet_framer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pcf_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pcf_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [63:0]                 cfg_value
);

  localparam int PROD_W = pcf_pkg::DUR_W + 10;

  logic [pcf_pkg::DUR_W-1:0]  chunk_duration_ms;
  logic                       end_with_zero_size;
  logic [pcf_pkg::FILL_W-1:0] chunk_fill;
  logic [pcf_pkg::TS_W-1:0]   current_timestamp;
  logic                       hdr_active;
  logic [pcf_pkg::HIDX_W-1:0] hdr_idx;
  logic [pcf_pkg::OFF_W-1:0]  hdr_size;

  logic [pcf_pkg::DUR_W-1:0]  dur;
  logic [PROD_W-1:0]          bpc_raw;
  logic [pcf_pkg::OFF_W-1:0]  bpc;
  logic [pcf_pkg::FILL_W-1:0] fill_inc;
  logic                       chunk_done;
  logic                       out_free;
  logic                       in_acc;
  logic                       hdr_step;
  logic                       hdr_last;
  logic [7:0]                 hdr_byte;
  logic [2:0]                 ts_sel;
  pcf_pkg::out_word_t         out_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !hdr_active && out_free;
  assign in_acc    = in_valid && in_ready;
  assign hdr_step  = hdr_active && out_free;
  assign hdr_last  = hdr_idx == pcf_pkg::HIDX_W'(pcf_pkg::HEADER_BYTES - 1);

  // clamped duration and chunk size
  always_comb begin
    dur = chunk_duration_ms;
    if (dur < pcf_pkg::DUR_W'(pcf_pkg::DURATION_MIN)) dur = pcf_pkg::DUR_W'(pcf_pkg::DURATION_MIN);
    if (dur > pcf_pkg::DUR_W'(pcf_pkg::DURATION_MAX)) dur = pcf_pkg::DUR_W'(pcf_pkg::DURATION_MAX);
    bpc_raw = PROD_W'(dur) * PROD_W'(pcf_pkg::BYTES_EACH_MS);
    if (bpc_raw > PROD_W'(pcf_pkg::MAX_CHUNK_BYTES)) begin
      bpc = pcf_pkg::OFF_W'(pcf_pkg::MAX_CHUNK_BYTES);
    end else begin
      bpc = bpc_raw[pcf_pkg::OFF_W-1:0];
    end
  end

  // fill wraps at its width, which also closes the chunk
  assign fill_inc   = chunk_fill + pcf_pkg::FILL_W'(1);
  assign chunk_done = ({1'b0, fill_inc} >= bpc) || (fill_inc == '0);

  assign ts_sel = 3'(hdr_idx - pcf_pkg::HIDX_W'(4));

  always_comb begin
    case (hdr_idx) inside
      4'd0:          hdr_byte = pcf_pkg::SIG0;
      4'd1:          hdr_byte = pcf_pkg::SIG1;
      4'd2:          hdr_byte = pcf_pkg::SIG2;
      4'd3:          hdr_byte = pcf_pkg::SIG3;
      [4'd4:4'd11]:  hdr_byte = current_timestamp[ts_sel*8 +: 8];
      4'd12:         hdr_byte = hdr_size[7:0];
      default:       hdr_byte = {4'd0, hdr_size[11:8]};
    endcase
  end

  always_comb begin
    out_next = '0;
    if (hdr_active) begin
      out_next.store_offset  = pcf_pkg::OFF_W'(hdr_idx);
      out_next.store_value   = hdr_byte;
      out_next.packet_commit = hdr_last;
      out_next.packet_length = hdr_last ?
        hdr_size + pcf_pkg::OFF_W'(pcf_pkg::HEADER_BYTES) : '0;
      out_next.run_last      = hdr_last;
    end else begin
      out_next.store_offset  = pcf_pkg::OFF_W'(pcf_pkg::HEADER_BYTES) +
                               pcf_pkg::OFF_W'(chunk_fill);
      out_next.store_value   = in_data.data_byte;
      out_next.run_last      = !chunk_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_duration_ms  <= pcf_pkg::DUR_W'(pcf_pkg::DURATION_RESET);
      end_with_zero_size <= 1'b0;
      current_timestamp  <= '0;
      chunk_fill         <= '0;
      hdr_active         <= 1'b0;
      hdr_idx            <= '0;
      hdr_size           <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pcf_pkg::CFG_DURATION: chunk_duration_ms  <= cfg_value[pcf_pkg::DUR_W-1:0];
          pcf_pkg::CFG_START_TS: current_timestamp  <= cfg_value;
          pcf_pkg::CFG_END_ZERO: end_with_zero_size <= cfg_value[0];
          default: ;
        endcase
      end

      if (hdr_step) begin
        hdr_idx <= hdr_idx + pcf_pkg::HIDX_W'(1);
        if (hdr_last) begin
          hdr_active        <= 1'b0;
          current_timestamp <= current_timestamp + pcf_pkg::TS_W'(dur);
        end
      end else if (in_acc) begin
        hdr_idx <= '0;
        if (in_data.func == pcf_pkg::FUNC_DATA) begin
          if (chunk_done) begin
            chunk_fill <= '0;
            hdr_active <= 1'b1;
            hdr_size   <= bpc;
          end else begin
            chunk_fill <= fill_inc;
          end
        end else begin
          // end marker: partial chunk dropped
          chunk_fill <= '0;
          hdr_active <= end_with_zero_size;
          hdr_size   <= '0;
        end
      end

      if (hdr_step || (in_acc && in_data.func == pcf_pkg::FUNC_DATA)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_step || (in_acc && in_data.func == pcf_pkg::FUNC_DATA)) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- test/pcf_checker.sv -----
module pcf_checker
  import pcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_value,
  output int          errors,
  output int          pending,
  output int          packets,
  output int          empty_packets
);
  timeunit 1ns;
  timeprecision 1ps;

  out_word_t         writes_due[$];
  logic [DUR_W-1:0]  duration;
  logic [TS_W-1:0]   stamp;
  logic              zero_on_end;
  logic [FILL_W-1:0] fill;
  int                n_bad = 0;
  int                n_pkt = 0;
  int                n_empty = 0;

  // out-of-range durations clamp to 1..64 ms
  function automatic int unsigned step_ms(logic [DUR_W-1:0] d);
    if (d < DURATION_MIN) return DURATION_MIN;
    if (d > DURATION_MAX) return DURATION_MAX;
    return 32'(d);
  endfunction

  function automatic int unsigned chunk_len(logic [DUR_W-1:0] d);
    int unsigned b;
    b = step_ms(d) * BYTES_EACH_MS;
    return (b > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : b;
  endfunction

  task automatic queue_write(int unsigned offs, logic [7:0] val, logic commit,
                             int unsigned len);
    out_word_t w;
    w.store_offset  = offs[OFF_W-1:0];
    w.store_value   = val;
    w.packet_commit = commit;
    w.packet_length = len[OFF_W-1:0];
    w.run_last      = 1'b0;
    writes_due.push_back(w);
  endtask

  // signature, little-endian stamp, little-endian size; commit rides on the last byte
  task automatic queue_header(int unsigned payload);
    logic [7:0] hdr [HEADER_BYTES];
    hdr[0] = SIG0;
    hdr[1] = SIG1;
    hdr[2] = SIG2;
    hdr[3] = SIG3;
    for (int i = 0; i < 8; i++) hdr[4+i] = stamp[8*i +: 8];
    hdr[12] = payload[7:0];
    hdr[13] = payload[15:8];
    for (int i = 0; i < HEADER_BYTES; i++) begin
      queue_write(i, hdr[i], i == HEADER_BYTES - 1,
                  (i == HEADER_BYTES - 1) ? HEADER_BYTES + payload : 0);
    end
    stamp = stamp + step_ms(duration);
  endtask

  task automatic take_input(in_word_t w);
    int          queued;
    int unsigned len;
    int unsigned next_fill;
    out_word_t   tail;
    queued = writes_due.size();
    if (w.func == FUNC_DATA) begin
      len = chunk_len(duration);
      queue_write(HEADER_BYTES + fill, w.data_byte, 1'b0, 0);
      next_fill = fill + 1;
      // a shortened chunk closes on the next byte
      if (next_fill >= len) begin
        fill = '0;
        queue_header(len);
      end else begin
        fill = next_fill[FILL_W-1:0];
      end
    end else begin
      fill = '0;
      if (zero_on_end) queue_header(0);
    end
    if (writes_due.size() > queued) begin
      tail = writes_due.pop_back();
      tail.run_last = 1'b1;
      writes_due.push_back(tail);
    end
  endtask

  task automatic note_bad(string what, out_word_t want, out_word_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t %s: exp off %0d val %02h commit %0b len %0d last %0b",
               $realtime, what, want.store_offset, want.store_value,
               want.packet_commit, want.packet_length, want.run_last);
      $display("%0t %s: got off %0d val %02h commit %0b len %0d last %0b",
               $realtime, what, got.store_offset, got.store_value,
               got.packet_commit, got.packet_length, got.run_last);
    end
  endtask

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst) begin
      writes_due.delete();
      duration    = DUR_W'(DURATION_RESET);
      stamp       = '0;
      zero_on_end = 1'b0;
      fill        = '0;
    end else begin
      // retire first: a word leaving now cannot stem from a word taken now
      if (out_valid && out_ready) begin
        got = out_data;
        if (writes_due.size() == 0) begin
          note_bad("unexpected store write", '0, got);
        end else begin
          want = writes_due.pop_front();
          if (got.store_offset !== want.store_offset ||
              got.store_value !== want.store_value ||
              got.packet_commit !== want.packet_commit ||
              got.packet_length !== want.packet_length ||
              got.run_last !== want.run_last) begin
            note_bad("store write differs", want, got);
          end
        end
        if (got.packet_commit === 1'b1) begin
          n_pkt++;
          if (got.packet_length == HEADER_BYTES) n_empty++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DURATION: duration = cfg_value[DUR_W-1:0];
          CFG_START_TS: stamp = cfg_value;
          CFG_END_ZERO: zero_on_end = cfg_value[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_input(in_data);
    end
    errors        <= n_bad;
    pending       <= writes_due.size();
    packets       <= n_pkt;
    empty_packets <= n_empty;
  end

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcf_pkg::*;

  localparam int LIMIT        = 1_500_000;
  localparam int SETTLE       = 4;
  localparam int TAIL         = 16;
  localparam int RANDOM_WORDS = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DURATION;
  logic [63:0] cfg_value = '0;

  int errors;
  int pending;
  int packets;
  int empty_packets;
  int cycles     = 0;
  int gap_max    = 12;
  int stall_max  = 12;
  int words_sent = 0;
  int ends_sent  = 0;
  int settings   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pcm_chunk_packet_framer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value)
  );

  pcf_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_value     (cfg_value),
    .errors        (errors),
    .pending       (pending),
    .packets       (packets),
    .empty_packets (empty_packets)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("pcm_chunk_packet_framer_top: mismatch");
      $finish;
    end
  end

  // receiver: random stall before each word
  initial begin
    int stall;
    forever begin
      stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_word(logic func, logic [7:0] b);
    in_word_t w;
    int       gap;
    w.func      = func;
    w.data_byte = b;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (func == FUNC_END) ends_sent++;
  endtask

  // hold off until every store write is back, plus a margin for a silent end marker
  task automatic drain(int margin);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic new_setting();
    logic [DUR_W-1:0] dur;
    logic [63:0]      noise;
    logic [63:0]      ts;
    logic             zb;
    case ($urandom_range(0, 9))
      0: dur = DUR_W'(0);
      1: dur = DUR_W'(64);
      2: dur = DUR_W'(127);
      3: dur = DUR_W'(65);
      default: dur = DUR_W'($urandom_range(1, 3));
    endcase
    noise = {$urandom, $urandom};
    // upper bits of the value are don't-care for the narrow registers
    write_reg(CFG_DURATION, ($urandom_range(0, 3) == 0) ? {noise[63:7], dur} : 64'(dur));
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0: ts = '0;
        1: ts = '1;
        2: ts = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(0, 63));
        default: ts = {$urandom, $urandom};
      endcase
      write_reg(CFG_START_TS, ts);
    end
    if ($urandom_range(0, 1) == 1) begin
      zb = 1'($urandom_range(0, 1));
      write_reg(CFG_END_ZERO, ($urandom_range(0, 3) == 0) ? {noise[63:1], zb} : 64'(zb));
    end
    cfg_valid <= 1'b0;
    gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
    settings++;
  endtask

  initial begin
    int random_sent;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: long chunk, no zero-size packet, so the end marker is silent
    send_word(FUNC_DATA, 8'h00);
    send_word(FUNC_DATA, 8'hFF);
    send_word(FUNC_DATA, 8'h5A);
    send_word(FUNC_END, 8'hFF);
    drain(SETTLE);

    // stamp at all ones wraps on the first header
    write_reg(CFG_DURATION, 64'd1);
    write_reg(CFG_START_TS, '1);
    write_reg(CFG_END_ZERO, 64'd1);
    cfg_valid <= 1'b0;
    settings++;
    send_word(FUNC_END, 8'h00);
    send_word(FUNC_END, 8'hA5);
    send_word(FUNC_DATA, 8'h01);
    send_word(FUNC_DATA, 8'h80);
    send_word(FUNC_DATA, 8'h7F);
    send_word(FUNC_DATA, 8'hAA);
    send_word(FUNC_END, 8'h55);
    drain(SETTLE);

    random_sent = 0;
    for (int ph = 0; random_sent < RANDOM_WORDS; ph++) begin
      new_setting();
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        if ((ph == 0 && i == n / 2) || $urandom_range(0, 59) == 0) drain(0);
        send_word(($urandom_range(0, 29) == 0) ? FUNC_END : FUNC_DATA, 8'($urandom));
      end
      random_sent += n;
      drain(SETTLE);
    end
    drain(TAIL);

    $display("%0d input words sent, %0d of them end markers, over %0d register settings",
             words_sent, ends_sent, settings);
    $display("%0d packets committed, %0d of them header-only",
             packets, empty_packets);
    if (errors == 0 && pending == 0) begin
      $display("pcm_chunk_packet_framer_top: match");
    end else begin
      $display("pcm_chunk_packet_framer_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pcf_pkg.sv
hw/rtl/pcm_chunk_packet_framer_top.sv
test/pcf_checker.sv
test/tb.sv
